/* design/lkc_pkg.sv */
// Package: shared types, constants and the threshold ladder for the keypad decoder
`timescale 1ns / 1ps
package lkc_pkg;

	localparam int SAMPLE_COUNT = 11;
	localparam int CNT_W        = 4;
	localparam int SMP_W        = 10;
	localparam int KEY_W        = 3;
	localparam int MS_W         = 32;
	localparam int DEB_W        = 16;

	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd150;
	localparam logic [SMP_W-1:0] MIN_RST      = '1;
	localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(SAMPLE_COUNT);

	localparam logic [SMP_W-1:0] TH_RIGHT = 10'd18;
	localparam logic [SMP_W-1:0] TH_UP    = 10'd27;
	localparam logic [SMP_W-1:0] TH_DOWN  = 10'd36;
	localparam logic [SMP_W-1:0] TH_LEFT  = 10'd43;
	localparam logic [SMP_W-1:0] TH_OK    = 10'd52;
	localparam logic [SMP_W-1:0] TH_SET   = 10'd60;

	localparam logic [KEY_W-1:0] KEY_NONE  = 3'd0;
	localparam logic [KEY_W-1:0] KEY_RIGHT = 3'd1;
	localparam logic [KEY_W-1:0] KEY_UP    = 3'd2;
	localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd3;
	localparam logic [KEY_W-1:0] KEY_LEFT  = 3'd4;
	localparam logic [KEY_W-1:0] KEY_OK    = 3'd5;
	localparam logic [KEY_W-1:0] KEY_SET   = 3'd6;

	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_EDGE   = 2'd1,
		FN_SAMPLE = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	function automatic logic [KEY_W-1:0] ladder_code(input logic [SMP_W-1:0] m);
		logic [KEY_W-1:0] k;
		if (m < TH_RIGHT)      k = KEY_RIGHT;
		else if (m < TH_UP)    k = KEY_UP;
		else if (m < TH_DOWN)  k = KEY_DOWN;
		else if (m < TH_LEFT)  k = KEY_LEFT;
		else if (m < TH_OK)    k = KEY_OK;
		else if (m < TH_SET)   k = KEY_SET;
		else                   k = KEY_NONE;
		return k;
	endfunction

endpackage

/* design/lkc_if.sv */
// Interfaces: input item channel and key result channel
`timescale 1ns / 1ps
interface lkc_in_if;
	import lkc_pkg::*;
	logic               valid;
	logic               ready;
	func_t              func;
	logic [SMP_W-1:0]   sample;
	modport source (output valid, output func, output sample, input ready);
	modport sink   (input valid, input func, input sample, output ready);
endinterface

interface lkc_out_if;
	import lkc_pkg::*;
	logic               valid;
	logic               ready;
	logic [KEY_W-1:0]   key;
	modport source (output valid, output key, input ready);
	modport sink   (input valid, input key, output ready);
endinterface

/* design/ladder_keypad_capture.sv */
// Top level: resistor-ladder keypad decoder with debounce, min capture and key buffer
//
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     func[1:0], sample[9:0]
//  out_ch    out  valid/ready     key[2:0]
//  cfg       in   cfg_we          cfg_wdata[15:0] (debounce_ms)
//
// One item per cycle sustained: an item is registered in the input stage, then
// updates the state; a read loads the result register from the key buffer.
// Only a read waiting on a full, stalled result register holds the input stage.
// Reset clears the counters, key buffer, capture state and debounce to 150 at once.
`timescale 1ns / 1ps
module ladder_keypad_capture
	import lkc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	lkc_in_if.sink            in_ch,
	lkc_out_if.source         out_ch,
	input  logic              cfg_we,
	input  logic [DEB_W-1:0]  cfg_wdata
);

	logic              v_s1;
	func_t             func_s1;
	logic [SMP_W-1:0]  sample_s1;

	logic [DEB_W-1:0]  debounce_q;
	logic [MS_W-1:0]   ms_q;
	logic [MS_W-1:0]   stamp_q;
	logic [KEY_W-1:0]  key_q;
	logic              capt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SMP_W-1:0]  min_q;
	logic              out_valid_q;
	logic [KEY_W-1:0]  out_key_q;

	logic              out_free;
	logic              s1_go;
	logic [MS_W-1:0]   elapsed;
	logic              edge_ok;
	logic [SMP_W-1:0]  new_min;
	logic [CNT_W-1:0]  cnt_nxt;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign s1_go       = v_s1 && ((func_s1 != FN_READ) || out_free);
	assign in_ch.ready = !v_s1 || s1_go;

	assign elapsed = ms_q - stamp_q;
	assign edge_ok = (key_q == KEY_NONE) && !capt_q && (elapsed >= MS_W'(debounce_q));
	assign new_min = (sample_s1 < min_q) ? sample_s1 : min_q;
	assign cnt_nxt = cnt_q + CNT_W'(1);

	assign out_ch.valid = out_valid_q;
	assign out_ch.key   = out_key_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_s1   <= in_ch.func;
			sample_s1 <= in_ch.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q    <= '0;
			stamp_q <= '0;
			key_q   <= KEY_NONE;
			capt_q  <= 1'b0;
			cnt_q   <= '0;
			min_q   <= MIN_RST;
		end else if (s1_go) begin
			case (func_s1)
				FN_TICK: begin
					ms_q <= ms_q + MS_W'(1);
				end
				FN_EDGE: begin
					if (edge_ok) begin
						stamp_q <= ms_q;
						capt_q  <= 1'b1;
						cnt_q   <= '0;
						min_q   <= MIN_RST;
					end
				end
				FN_SAMPLE: begin
					if (capt_q) begin
						if (cnt_nxt >= CNT_LAST) begin
							key_q  <= ladder_code(new_min);
							capt_q <= 1'b0;
							cnt_q  <= '0;
							min_q  <= MIN_RST;
						end else begin
							cnt_q <= cnt_nxt;
							min_q <= new_min;
						end
					end
				end
				FN_READ: begin
					key_q <= KEY_NONE;
				end
				default: begin
					ms_q <= ms_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && (func_s1 == FN_READ)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (func_s1 == FN_READ)) begin
			out_key_q <= key_q;
		end
	end

`ifndef SYNTH
	a_capt_empty: assert property (@(posedge clk) disable iff (!arst_n)
		capt_q |-> (key_q == KEY_NONE))
		else $error("capture running with a key buffered");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_LAST)
		else $error("sample count beyond capture length");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!capt_q |-> ((cnt_q == '0) && (min_q == MIN_RST)))
		else $error("idle capture state not cleared");

	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (func_s1 == FN_READ) && out_valid_q && !out_ch.ready) |-> !in_ch.ready)
		else $error("input taken while a read is blocked");

	a_key_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && (func_s1 == FN_READ)) |=> (key_q == KEY_NONE))
		else $error("key buffer not cleared by read");
`endif

endmodule

/* bench/lkc_key_checker.sv */
// Checker: predicts keypad decoder results from observed transfers and compares keys
`timescale 1ns / 1ps
module lkc_key_checker
	import lkc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	lkc_in_if                in_mon,
	lkc_out_if               out_mon,
	input  logic             cfg_we,
	input  logic [DEB_W-1:0] cfg_wdata,
	output int               errors,
	output int               pending
);

	logic [DEB_W-1:0] deb;
	logic [MS_W-1:0]  ms_now;
	logic [MS_W-1:0]  stamp;
	logic [KEY_W-1:0] held_key;
	logic             busy;
	logic [CNT_W-1:0] n_smp;
	logic [SMP_W-1:0] lowest;
	logic [KEY_W-1:0] keys_due [$];
	logic [KEY_W-1:0] due;
	int               fail_cnt;

	function automatic logic [KEY_W-1:0] key_of(input logic [SMP_W-1:0] m);
		logic [SMP_W-1:0] bounds [6];
		bounds = '{TH_RIGHT, TH_UP, TH_DOWN, TH_LEFT, TH_OK, TH_SET};
		for (int i = 0; i < 6; i++)
			if (m < bounds[i])
				return KEY_W'(i + 1);
		return KEY_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb      = DEBOUNCE_RST;
			ms_now   = '0;
			stamp    = '0;
			held_key = KEY_NONE;
			busy     = 1'b0;
			n_smp    = '0;
			lowest   = MIN_RST;
			fail_cnt = 0;
			keys_due.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				deb = cfg_wdata;
			if (in_mon.valid && in_mon.ready) begin
				case (in_mon.func)
					FN_TICK: ms_now = ms_now + MS_W'(1);
					FN_EDGE: begin
						if (held_key == KEY_NONE && !busy && (ms_now - stamp) >= MS_W'(deb)) begin
							stamp  = ms_now;
							busy   = 1'b1;
							n_smp  = '0;
							lowest = MIN_RST;
						end
					end
					FN_SAMPLE: begin
						if (busy) begin
							if (in_mon.sample < lowest)
								lowest = in_mon.sample;
							n_smp = n_smp + CNT_W'(1);
							if (n_smp >= CNT_LAST) begin
								held_key = key_of(lowest);
								busy     = 1'b0;
								n_smp    = '0;
								lowest   = MIN_RST;
							end
						end
					end
					default: begin
						keys_due.push_back(held_key);
						held_key = KEY_NONE;
					end
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				if (keys_due.size() == 0) begin
					$error("key: expected none, actual %0d", out_mon.key);
					fail_cnt++;
				end else begin
					due = keys_due.pop_front();
					if (out_mon.key !== due) begin
						$error("key: expected %0d, actual %0d", due, out_mon.key);
						fail_cnt++;
					end
				end
			end
			errors  <= fail_cnt;
			pending <= keys_due.size();
		end
	end

endmodule

/* bench/tb.sv */
// Testbench top: drives keypad items and debounce writes, then gives the verdict
`timescale 1ns / 1ps
module tb;
	import lkc_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [DEB_W-1:0] cfg_wdata;
	logic [DEB_W-1:0] cur_deb;
	int               errors;
	int               pending;
	int               src_idle;
	int               sink_idle;
	int               items_sent;

	lkc_in_if  in_ch ();
	lkc_out_if out_ch ();

	ladder_keypad_capture dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	lkc_key_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_mon   (in_ch),
		.out_mon  (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.errors   (errors),
		.pending  (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= sink_idle);

	function automatic logic [SMP_W-1:0] any_smp();
		return SMP_W'($urandom_range(1023));
	endfunction

	task automatic send(input func_t f, input logic [SMP_W-1:0] s);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.func   <= f;
		in_ch.sample <= s;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_deb(input logic [DEB_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_deb    = v;
	endtask

	// ticks, edge, a full capture with a chosen minimum, then usually a read
	task automatic press();
		int               n_ticks;
		int               pos;
		logic [SMP_W-1:0] lo;
		logic [SMP_W-1:0] marks [14];
		marks = '{10'd0, 10'd17, 10'd18, 10'd26, 10'd27, 10'd35, 10'd36,
		          10'd42, 10'd43, 10'd51, 10'd52, 10'd59, 10'd60, 10'd1023};
		n_ticks = $urandom_range(cur_deb <= 200 ? cur_deb + 4 : 8);
		repeat (n_ticks) send(FN_TICK, any_smp());
		send(FN_EDGE, any_smp());
		case ($urandom_range(2))
			0: lo = marks[$urandom_range(13)];
			1: lo = SMP_W'($urandom_range(70));
			default: lo = any_smp();
		endcase
		pos = $urandom_range(SAMPLE_COUNT - 1);
		for (int i = 0; i < SAMPLE_COUNT; i++) begin
			if ($urandom_range(99) < 8)
				send(func_t'($urandom_range(3)), any_smp());
			send(FN_SAMPLE, i == pos ? lo : SMP_W'($urandom_range(1023, lo)));
		end
		if ($urandom_range(99) < 85)
			send(FN_READ, any_smp());
		if ($urandom_range(99) < 10)
			send(FN_READ, any_smp());
	endtask

	task automatic run_chunk(input logic [DEB_W-1:0] v, input int n);
		int stop;
		set_deb(v);
		stop = items_sent + n;
		while (items_sent < stop)
			press();
	endtask

	initial begin
		arst_n       <= 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.func   <= FN_TICK;
		in_ch.sample <= '0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		cur_deb       = DEBOUNCE_RST;
		src_idle      = 17;
		sink_idle     = 75;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty buffer, sample while idle, edge inside the reset debounce window
		send(FN_READ, '0);
		send(FN_SAMPLE, '1);
		send(FN_EDGE, '0);
		send(FN_READ, '1);

		// zero debounce: edge accepted, a further edge ignored, read mid-capture
		set_deb('0);
		send(FN_EDGE, '0);
		send(FN_EDGE, '1);
		send(FN_READ, '0);
		for (int i = 0; i < SAMPLE_COUNT; i++)
			send(FN_SAMPLE, i == 3 ? '0 : '1);
		send(FN_READ, '0);
		send(FN_READ, '1);

		run_chunk('1, 60);
		run_chunk(DEB_W'($urandom_range(30, 1)), 80);
		run_chunk('0, 80);

		src_idle  = 75;
		sink_idle = 17;
		run_chunk(DEB_W'(1), 80);
		run_chunk(DEB_W'($urandom_range(30, 1)), 80);
		run_chunk(DEB_W'(20), 80);

		src_idle  = 0;
		sink_idle = 0;
		run_chunk(DEBOUNCE_RST, 60);
		run_chunk('0, 80);
		run_chunk(DEB_W'($urandom_range(30, 1)), 80);

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

/* ladder_keypad_capture.f */
design/lkc_pkg.sv
design/lkc_if.sv
design/ladder_keypad_capture.sv
bench/lkc_key_checker.sv
bench/tb.sv
